@@ rtl/m4vt_pkg.sv @@
// Package for the 4x4 matrix-vector transform: product kinds, pipeline control
// struct, register map constants and the identity reset image of the matrix.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package m4vt_pkg;

  localparam int NUM_LANES  = 4;
  localparam int NUM_PAIRS  = 8;
  localparam int NUM_ENTRY  = 16;
  localparam int FIELD_W    = 32;
  localparam int PAIR_W     = 64;
  localparam int PAIR_IDX_W = 3;
  localparam int ADDR_W     = 6;
  localparam int ADDR_LSB   = 3;

  typedef enum logic {
    FUNC_MXV = 1'b0,
    FUNC_VXM = 1'b1
  } func_t;

  typedef struct packed {
    logic ld_mul;
    logic ld_sum;
    logic ld_out;
  } pipe_ctl_t;

  localparam logic [PAIR_W-1:0] PAIR_RST [NUM_PAIRS] = '{
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000
  };

endpackage

`default_nettype wire

@@ rtl/matrix4_vector_transform.sv @@
// Top level of the 4x4 matrix-vector transform: matrix registers behind the
// configuration port, four parallel lanes, merging stage and pipeline control.
// Depends on m4vt_pkg, m4vt_lane and m4vt_merge.
//
//   Port group   Dir   Payload
//   in_*         in    tdata: vec_x, vec_y, vec_z, vec_w; tuser: func
//   out_*        out   tdata: res_x, res_y, res_z, res_w; tuser: saturated
//   p* (APB)     in    eight 64-bit matrix pairs at byte address 8*i
//
// One request per cycle is taken while in_tready is high; each accepted request
// passes through the multiply, sum and saturate stages in that order.
// Reset clears the stage valid bits and loads the identity matrix.
// Each stage holds while the one after it is full and stalled, so a bubble
// anywhere lets a new request in even when out_tready is low.
`timescale 1ns / 1ps
`default_nettype none

module matrix4_vector_transform #(
  parameter int COMPONENT_WIDTH = 32,
  parameter int FRACTION_BITS   = 16
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [127:0] in_tdata,   // vec_x, vec_y, vec_z, vec_w
  input  wire  [0:0]   in_tuser,   // func
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [127:0] out_tdata,  // res_x, res_y, res_z, res_w
  output logic [0:0]   out_tuser,  // saturated
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [5:0]   paddr,
  input  wire  [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  import m4vt_pkg::*;

  localparam int CW = COMPONENT_WIDTH;
  localparam int SW = 2 * COMPONENT_WIDTH + 2;

  logic [PAIR_W-1:0]     pair_r   [NUM_PAIRS];
  logic [PAIR_W-1:0]     pair_nxt [NUM_PAIRS];
  logic [PAIR_IDX_W-1:0] cfg_idx;
  logic                  cfg_wr;

  logic signed [CW-1:0]  ent [NUM_ENTRY];
  logic [4*CW-1:0]       col_coef [NUM_LANES];
  logic [4*CW-1:0]       row_coef [NUM_LANES];
  logic [4*CW-1:0]       vec_in;
  func_t                 func;

  logic                  v1_r, v2_r, v3_r;
  logic                  v1_nxt, v2_nxt, v3_nxt;
  logic                  rdy1, rdy2, rdy3;
  pipe_ctl_t             ctl;
  logic signed [SW-1:0]  lane_sum [NUM_LANES];
  logic                  sat;

  assign cfg_idx = paddr[ADDR_W-1:ADDR_LSB];
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign pready  = 1'b1;
  assign prdata  = pair_r[cfg_idx];

  always_comb begin
    pair_nxt = pair_r;
    if (cfg_wr) begin
      pair_nxt[cfg_idx] = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_r <= PAIR_RST;
    end else begin
      pair_r <= pair_nxt;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_ENTRY; k++) begin
      ent[k] = signed'(pair_r[k/2][(k%2)*FIELD_W +: CW]);
    end
    for (int i = 0; i < NUM_LANES; i++) begin
      for (int j = 0; j < NUM_LANES; j++) begin
        col_coef[i][j*CW +: CW] = ent[4*j+i];
        row_coef[i][j*CW +: CW] = ent[4*i+j];
      end
    end
    for (int j = 0; j < NUM_LANES; j++) begin
      vec_in[j*CW +: CW] = in_tdata[j*FIELD_W +: CW];
    end
  end

  assign func = func_t'(in_tuser[0]);

  assign rdy3      = ~v3_r | out_tready;
  assign rdy2      = ~v2_r | rdy3;
  assign rdy1      = ~v1_r | rdy2;
  assign in_tready = rdy1;

  assign ctl.ld_mul = rdy1;
  assign ctl.ld_sum = rdy2;
  assign ctl.ld_out = rdy3;

  always_comb begin
    v1_nxt = rdy1 ? in_tvalid : v1_r;
    v2_nxt = rdy2 ? v1_r      : v2_r;
    v3_nxt = rdy3 ? v2_r      : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    m4vt_lane #(
      .COMPONENT_WIDTH (COMPONENT_WIDTH),
      .FRACTION_BITS   (FRACTION_BITS)
    ) u_lane (
      .clk      (clk),
      .ctl      (ctl),
      .func     (func),
      .col_coef (col_coef[i]),
      .row_coef (row_coef[i]),
      .vec      (vec_in),
      .sum      (lane_sum[i])
    );
  end

  m4vt_merge #(
    .COMPONENT_WIDTH (COMPONENT_WIDTH)
  ) u_merge (
    .clk (clk),
    .ctl (ctl),
    .sum (lane_sum),
    .res (out_tdata),
    .sat (sat)
  );

  assign out_tuser  = sat;
  assign out_tvalid = v3_r;

`ifndef SYNTHESIS
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v1_r)
    else $error("accepted request did not enter the multiply stage");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && !out_tready) |-> !in_tready)
    else $error("request accepted while the pipeline is full and stalled");

  a_sign_ext: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[FIELD_W-1:CW-1] == '0) ||
                    (out_tdata[FIELD_W-1:CW-1] == '1)))
    else $error("result component is not a sign-extended narrow value");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite) |=> (pair_r[$past(cfg_idx)] == $past(pwdata)))
    else $error("configuration write did not update the matrix pair");
`endif

endmodule

`default_nettype wire

@@ rtl/m4vt_lane.sv @@
// One output component of the transform: picks a matrix column or row,
// forms four registered products, then a registered sum of the shifted products.
// Depends on m4vt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module m4vt_lane #(
  parameter int COMPONENT_WIDTH = 32,
  parameter int FRACTION_BITS   = 16
) (
  input  wire                                  clk,
  input  wire m4vt_pkg::pipe_ctl_t             ctl,
  input  wire m4vt_pkg::func_t                 func,
  input  wire  [4*COMPONENT_WIDTH-1:0]         col_coef,
  input  wire  [4*COMPONENT_WIDTH-1:0]         row_coef,
  input  wire  [4*COMPONENT_WIDTH-1:0]         vec,
  output logic signed [2*COMPONENT_WIDTH+1:0]  sum
);
  import m4vt_pkg::*;

  localparam int CW = COMPONENT_WIDTH;
  localparam int PW = 2 * COMPONENT_WIDTH;
  localparam int SW = 2 * COMPONENT_WIDTH + 2;

  logic signed [CW-1:0] coef     [NUM_LANES];
  logic signed [CW-1:0] vec_e    [NUM_LANES];
  logic signed [PW-1:0] prod_nxt [NUM_LANES];
  logic signed [PW-1:0] prod_r   [NUM_LANES];
  logic signed [SW-1:0] sum_nxt;
  logic signed [SW-1:0] sum_r;

  always_comb begin
    for (int j = 0; j < NUM_LANES; j++) begin
      coef[j]     = (func == FUNC_VXM) ? signed'(row_coef[j*CW +: CW])
                                       : signed'(col_coef[j*CW +: CW]);
      vec_e[j]    = signed'(vec[j*CW +: CW]);
      prod_nxt[j] = PW'(coef[j]) * PW'(vec_e[j]);
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int j = 0; j < NUM_LANES; j++) begin
      sum_nxt = sum_nxt + SW'(prod_r[j] >>> FRACTION_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_mul) begin
      for (int j = 0; j < NUM_LANES; j++) begin
        prod_r[j] <= prod_nxt[j];
      end
    end
    if (ctl.ld_sum) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum = sum_r;

endmodule

`default_nettype wire

@@ rtl/m4vt_merge.sv @@
// Merging stage: saturates the four lane sums, sign-extends them to the field
// width, ORs the clip flags and holds the result in the output register.
// Depends on m4vt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module m4vt_merge #(
  parameter int COMPONENT_WIDTH = 32
) (
  input  wire                                   clk,
  input  wire m4vt_pkg::pipe_ctl_t              ctl,
  input  wire signed [2*COMPONENT_WIDTH+1:0]    sum [m4vt_pkg::NUM_LANES],
  output logic [m4vt_pkg::NUM_LANES*m4vt_pkg::FIELD_W-1:0] res,
  output logic                                  sat
);
  import m4vt_pkg::*;

  localparam int CW = COMPONENT_WIDTH;
  localparam int SW = 2 * COMPONENT_WIDTH + 2;
  localparam logic signed [SW-1:0] HI = SW'({(CW-1){1'b1}});
  localparam logic signed [SW-1:0] LO = ~HI;

  logic signed [CW-1:0]               clip_v [NUM_LANES];
  logic [NUM_LANES-1:0]               clip_f;
  logic [NUM_LANES*FIELD_W-1:0]       res_nxt;
  logic [NUM_LANES*FIELD_W-1:0]       res_r;
  logic                               sat_nxt;
  logic                               sat_r;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      if (sum[i] > HI) begin
        clip_v[i] = HI[CW-1:0];
        clip_f[i] = 1'b1;
      end else if (sum[i] < LO) begin
        clip_v[i] = LO[CW-1:0];
        clip_f[i] = 1'b1;
      end else begin
        clip_v[i] = sum[i][CW-1:0];
        clip_f[i] = 1'b0;
      end
      res_nxt[i*FIELD_W +: FIELD_W] = FIELD_W'(clip_v[i]);
    end
    sat_nxt = |clip_f;
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign res = res_r;
  assign sat = sat_r;

endmodule

`default_nettype wire

@@ sim/matrix4_vector_transform_tb.sv @@
// Self-checking testbench for matrix4_vector_transform: drives vector requests and matrix
// register writes, predicts every transformed vector and compares it with the output stream.
// Depends on m4vt_pkg and the matrix4_vector_transform RTL.
`timescale 1ns / 1ps

module matrix4_vector_transform_tb;
  import m4vt_pkg::*;

  localparam int     FRAC_BITS   = 16;
  localparam int     CYCLE_LIMIT = 300000;
  localparam longint COMP_MAX    = 64'sd2147483647;
  localparam longint COMP_MIN    = -64'sd2147483648;

  typedef logic [3:0][31:0] vec4_t;

  typedef struct packed {
    logic  saturated;
    vec4_t res;
  } xform_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;   // vec_x, vec_y, vec_z, vec_w
  logic [0:0]   in_tuser;   // func
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;  // res_x, res_y, res_z, res_w
  logic [0:0]   out_tuser;  // saturated
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [5:0]   paddr;
  logic [63:0]  pwdata;
  logic [63:0]  prdata;
  logic         pready;

  logic [63:0]  matrix_image [NUM_PAIRS];
  xform_t       pending_results [$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  bit           sender_steady = 1'b0;
  bit           receiver_steady = 1'b0;
  int           stall_request = 0;
  int           stall_left = 0;

  matrix4_vector_transform uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("matrix4_vector_transform verification failed");
      $finish;
    end
  end

  // Each product is floored by the fraction shift, the four are summed exactly,
  // and the sum is clipped to 32 bits.
  function automatic xform_t transform_vector(input func_t f, input vec4_t v);
    xform_t      r;
    longint      acc;
    longint      prod;
    logic [31:0] e;
    int          k;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      acc = 0;
      for (int j = 0; j < 4; j++) begin
        k = (f == FUNC_VXM) ? 4 * i + j : 4 * j + i;
        e = k[0] ? matrix_image[k >> 1][63:32] : matrix_image[k >> 1][31:0];
        prod = longint'(signed'(e)) * longint'(signed'(v[j]));
        acc += prod >>> FRAC_BITS;
      end
      if (acc > COMP_MAX) begin
        r.res[i] = 32'h7FFF_FFFF;
        r.saturated = 1'b1;
      end else if (acc < COMP_MIN) begin
        r.res[i] = 32'h8000_0000;
        r.saturated = 1'b1;
      end else begin
        r.res[i] = acc[31:0];
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] random_q16();
    logic [31:0] val;
    case ($urandom_range(9))
      0, 1, 2, 3: val = 32'($urandom_range(0, 32'h80000)) - 32'h40000;
      4, 5, 6:    val = $urandom;
      7:          val = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      8:          val = $urandom_range(1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
      default:    val = $urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000;
    endcase
    return val;
  endfunction

  always @(negedge clk) begin
    if (stall_request > 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= receiver_steady || ($urandom_range(99) >= 34);
    end
  end

  always @(posedge clk) begin
    xform_t got;
    xform_t want;
    bit     bad;
    if (rst_n && out_tvalid && out_tready) begin
      got.res = out_tdata;
      got.saturated = out_tuser[0];
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result res=%h sat=%b.", got.res, got.saturated);
      end else begin
        want = pending_results.pop_front();
        bad = (got.saturated != want.saturated);
        for (int i = 0; i < 4; i++)
          if (got.res[i] != want.res[i])
            bad = 1'b1;
        if (bad) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Result mismatch: expected res=%h sat=%b, got res=%h sat=%b.",
                     want.res, want.saturated, got.res, got.saturated);
        end
      end
    end
  end

  task automatic send_vector(input func_t f, input vec4_t v);
    while (!sender_steady && $urandom_range(99) < 34) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tuser  <= f;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(transform_vector(f, v));
  endtask

  task automatic drain_pipeline();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_pair(input int idx, input logic [63:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 6'(idx * 8);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    matrix_image[idx] = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_matrix_readback();
    for (int idx = 0; idx < NUM_PAIRS; idx++) begin
      @(negedge clk);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= 6'(idx * 8);
      @(negedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (prdata != matrix_image[idx]) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Register %0d readback: expected %h, got %h.",
                   idx, matrix_image[idx], prdata);
      end
      @(negedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  task automatic fill_matrix(input logic [31:0] entry_val);
    for (int idx = 0; idx < NUM_PAIRS; idx++)
      write_pair(idx, {entry_val, entry_val});
  endtask

  task automatic test_reset_identity();
    check_matrix_readback();
    send_vector(FUNC_MXV, {32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
    send_vector(FUNC_VXM, {32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
    send_vector(FUNC_MXV, {32'h0000_8000, 32'hFFFD_0000, 32'h0002_8000, 32'h0001_0000});
    send_vector(FUNC_VXM, {32'h0000_8000, 32'hFFFD_0000, 32'h0002_8000, 32'h0001_0000});
    drain_pipeline();
  endtask

  // The two full-scale patterns drive the sums far past 32 bits in both directions.
  task automatic test_extreme_matrices();
    logic [31:0] patterns [3] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001};
    for (int p = 0; p < 3; p++) begin
      fill_matrix(patterns[p]);
      check_matrix_readback();
      send_vector(FUNC_MXV, {4{32'h7FFF_FFFF}});
      send_vector(FUNC_VXM, {4{32'h8000_0000}});
      send_vector(FUNC_MXV, {32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
      send_vector(FUNC_VXM, {4{32'hFFFF_FFFF}});
      drain_pipeline();
    end
    for (int idx = 0; idx < NUM_PAIRS; idx++)
      write_pair(idx, {32'h0001_0000 + 32'(idx), 32'hFFFF_0000 - 32'(idx)});
    send_vector(FUNC_MXV, {32'h0000_0003, 32'hFFFF_FFFD, 32'h0001_0000, 32'hFFFF_8000});
    send_vector(FUNC_VXM, {32'h0000_0003, 32'hFFFF_FFFD, 32'h0001_0000, 32'hFFFF_8000});
    drain_pipeline();
  endtask

  task automatic test_random_settings(input int phases, input int items_per_phase);
    vec4_t v;
    for (int p = 0; p < phases; p++) begin
      for (int idx = 0; idx < NUM_PAIRS; idx++)
        write_pair(idx, {random_q16(), random_q16()});
      check_matrix_readback();
      sender_steady   = (p == 2);
      receiver_steady = (p == 2);
      for (int n = 0; n < items_per_phase; n++) begin
        for (int c = 0; c < 4; c++)
          v[c] = random_q16();
        send_vector(func_t'($urandom_range(1)), v);
      end
      drain_pipeline();
    end
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall requests.
  task automatic test_output_stall();
    vec4_t v;
    sender_steady = 1'b1;
    stall_request = 120;
    for (int n = 0; n < 50; n++) begin
      for (int c = 0; c < 4; c++)
        v[c] = random_q16();
      send_vector(func_t'($urandom_range(1)), v);
    end
    sender_steady = 1'b0;
    drain_pipeline();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    out_tready = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    for (int idx = 0; idx < NUM_PAIRS; idx++)
      matrix_image[idx] = PAIR_RST[idx];
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_reset_identity();
    test_extreme_matrices();
    test_random_settings(7, 72);
    test_output_stall();

    drain_pipeline();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("matrix4_vector_transform verification clean");
    end else begin
      $display("matrix4_vector_transform verification failed");
    end
    $finish;
  end

endmodule
